// ===== hdl/ordered_key_list_engine_defines.svh =====
// Shared assertion macros for the ordered key list engine.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef ORDERED_KEY_LIST_ENGINE_DEFINES_SVH
`define ORDERED_KEY_LIST_ENGINE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define OKL_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define OKL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/okl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package okl_pkg;

  // List size and field widths.
  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 32;
  localparam int ACT_W    = 3;
  localparam int STAT_W   = 2;
  localparam int COUNT_W  = 5;

  // Command codes carried in the action field.
  localparam logic [ACT_W-1:0] ACT_INS_FRONT  = ACT_W'(0);
  localparam logic [ACT_W-1:0] ACT_INS_BACK   = ACT_W'(1);
  localparam logic [ACT_W-1:0] ACT_INS_SORTED = ACT_W'(2);
  localparam logic [ACT_W-1:0] ACT_DEL_FRONT  = ACT_W'(3);
  localparam logic [ACT_W-1:0] ACT_DEL_BACK   = ACT_W'(4);
  localparam logic [ACT_W-1:0] ACT_DEL_KEY    = ACT_W'(5);

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    ST_OK,
    ST_EMPTY,
    ST_NOTFOUND,
    ST_FULL
  } status_t;

  // Walk pointer updates requested by the controller.
  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_ZERO,
    PTR_ONE,
    PTR_INC,
    PTR_COUNT,
    PTR_LAST
  } ptr_op_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic    load;
    ptr_op_t ptr_op;
    logic    do_insert;
    logic    do_remove;
    logic    set_status;
    status_t status;
    logic    publish;
  } okl_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic             count_zero;
    logic             count_full;
    logic             ptr_at_end;
    logic             cur_lt_key;
    logic             key_lt_cur;
    logic             cur_eq_key;
    logic             out_free;
  } okl_stat_t;

endpackage

`default_nettype wire

// ===== hdl/okl_cmd_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Command channel: one beat carries an action and a key.
interface okl_cmd_if import okl_pkg::*;
  ();
  logic                    valid;
  logic                    ready;
  logic [ACT_W-1:0]        action;
  logic signed [KEY_W-1:0] key;

  modport source (output valid, output action, output key, input ready);
  modport sink   (input valid, input action, input key, output ready);
endinterface

`default_nettype wire

// ===== hdl/okl_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Response channel: one beat per command.
interface okl_rsp_if import okl_pkg::*;
  ();
  logic                    valid;
  logic                    ready;
  logic [STAT_W-1:0]       status;
  logic [COUNT_W-1:0]      entry_count;
  logic signed [KEY_W-1:0] removed_key;

  modport source (output valid, output status, output entry_count, output removed_key,
                  input ready);
  modport sink   (input valid, input status, input entry_count, input removed_key,
                  output ready);
endinterface

`default_nettype wire

// ===== hdl/okl_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "ordered_key_list_engine_defines.svh"

module okl_datapath import okl_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire okl_cmd_t                cmd,
  output okl_stat_t                    stat,
  input  wire logic [ACT_W-1:0]        in_action,
  input  wire logic signed [KEY_W-1:0] in_key,
  input  wire logic                    out_ready,
  output logic                         out_valid,
  output status_t                      out_status,
  output logic [COUNT_W-1:0]           out_count,
  output logic signed [KEY_W-1:0]      out_removed
);

  logic signed [KEY_W-1:0] entries [CAPACITY];
  logic [ACT_W-1:0]        action_r;
  logic signed [KEY_W-1:0] key_r;
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        ptr;
  status_t                 res_status;
  logic signed [KEY_W-1:0] res_removed;
  logic signed [KEY_W-1:0] cur;

  // Single read port of the list, addressed by the walk pointer.
  assign cur = entries[ptr[IDX_W-1:0]];

  // Status toward the controller.
  always_comb begin
    stat.action     = action_r;
    stat.count_zero = (count == '0);
    stat.count_full = (count == CNT_W'(CAPACITY));
    stat.ptr_at_end = (ptr == count);
    stat.cur_lt_key = (cur < key_r);
    stat.key_lt_cur = (key_r < cur);
    stat.cur_eq_key = (cur == key_r);
    stat.out_free   = !out_valid || out_ready;
  end

  // Insert puts the key at ptr and shifts later slots up; removal shifts down.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_slot
    localparam logic [CNT_W-1:0] SLOT = CNT_W'(i);
    logic signed [KEY_W-1:0] below;
    logic signed [KEY_W-1:0] above;

    if (i > 0) begin : g_below
      assign below = entries[i-1];
    end else begin : g_head
      assign below = key_r;
    end

    if (i < CAPACITY - 1) begin : g_above
      assign above = entries[i+1];
    end else begin : g_tail
      assign above = entries[i];
    end

    always_ff @(posedge clk) begin
      if (cmd.do_insert && SLOT == ptr) begin
        entries[i] <= key_r;
      end else if (cmd.do_insert && SLOT > ptr) begin
        entries[i] <= below;
      end else if (cmd.do_remove && SLOT >= ptr) begin
        entries[i] <= above;
      end
    end
  end

  // Command capture, walk pointer, count and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      ptr       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        action_r    <= in_action;
        key_r       <= in_key;
        res_status  <= ST_OK;
        res_removed <= '0;
      end

      case (cmd.ptr_op)
        PTR_ZERO:  ptr <= '0;
        PTR_ONE:   ptr <= CNT_W'(1);
        PTR_INC:   ptr <= ptr + CNT_W'(1);
        PTR_COUNT: ptr <= count;
        PTR_LAST:  ptr <= count - CNT_W'(1);
        default:   ptr <= ptr;
      endcase

      if (cmd.do_insert) begin
        count <= count + CNT_W'(1);
      end else if (cmd.do_remove) begin
        count       <= count - CNT_W'(1);
        res_removed <= cur;
      end

      if (cmd.set_status) begin
        res_status <= cmd.status;
      end

      // Output register holds the result beat until the sink takes it.
      if (cmd.publish) begin
        out_valid   <= 1'b1;
        out_status  <= res_status;
        out_count   <= COUNT_W'(count);
        out_removed <= res_removed;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `OKL_ASSERT_NEXT(a_insert_count, cmd.do_insert, count == $past(count) + CNT_W'(1), "insert did not grow the count")
  `OKL_ASSERT_NEXT(a_remove_count, cmd.do_remove, count == $past(count) - CNT_W'(1), "removal did not shrink the count")
  `OKL_ASSERT_IMPL(a_insert_room, cmd.do_insert, !stat.count_full && ptr <= count, "insert into a full list or past the end")
  `OKL_ASSERT_IMPL(a_remove_held, cmd.do_remove, count != '0 && ptr < count, "removal of an entry that is not held")
  `OKL_ASSERT_IMPL(a_publish_free, cmd.publish, !out_valid || out_ready, "result overwrote a waiting beat")

endmodule

`default_nettype wire

// ===== hdl/okl_controller.sv =====
`timescale 1ns / 1ps
`default_nettype none

module okl_controller import okl_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire okl_stat_t stat,
  output okl_cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SEARCH,
    S_INSERT,
    S_REMOVE,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencing of one command: decode, optional walk, optional list update, result.
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.ptr_op = PTR_HOLD;
    cmd.status = ST_OK;

    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          cmd.ptr_op = PTR_ZERO;
          state_next = S_DECIDE;
        end
      end

      // The pointer is at the head here, so the head compare is available.
      S_DECIDE: begin
        case (stat.action)
          ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_SORTED: begin
            if (stat.count_full) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_FULL;
              state_next     = S_DONE;
            end else if (stat.action == ACT_INS_FRONT) begin
              state_next = S_INSERT;
            end else if (stat.action == ACT_INS_BACK) begin
              cmd.ptr_op = PTR_COUNT;
              state_next = S_INSERT;
            end else if (stat.count_zero || stat.key_lt_cur) begin
              state_next = S_INSERT;
            end else begin
              cmd.ptr_op = PTR_ONE;
              state_next = S_SEARCH;
            end
          end
          ACT_DEL_FRONT, ACT_DEL_BACK, ACT_DEL_KEY: begin
            if (stat.count_zero) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_EMPTY;
              state_next     = S_DONE;
            end else if (stat.action == ACT_DEL_FRONT) begin
              state_next = S_REMOVE;
            end else if (stat.action == ACT_DEL_BACK) begin
              cmd.ptr_op = PTR_LAST;
              state_next = S_REMOVE;
            end else begin
              state_next = S_SEARCH;
            end
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end

      // One entry is examined per cycle.
      S_SEARCH: begin
        if (stat.action == ACT_INS_SORTED) begin
          if (stat.ptr_at_end || !stat.cur_lt_key) begin
            state_next = S_INSERT;
          end else begin
            cmd.ptr_op = PTR_INC;
          end
        end else if (stat.ptr_at_end) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_NOTFOUND;
          state_next     = S_DONE;
        end else if (stat.cur_eq_key) begin
          state_next = S_REMOVE;
        end else begin
          cmd.ptr_op = PTR_INC;
        end
      end

      S_INSERT: begin
        cmd.do_insert = 1'b1;
        state_next    = S_DONE;
      end

      S_REMOVE: begin
        cmd.do_remove = 1'b1;
        state_next    = S_DONE;
      end

      S_DONE: begin
        if (stat.out_free) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/ordered_key_list_engine.sv =====
// Ordered list of up to CAPACITY (16) signed 32-bit keys. Each command beat inserts a key at
// the front, the back or its sorted place, or removes the front, the back or the first entry
// equal to the key, and yields exactly one response beat with status, new count and removed
// key. Commands are handled one at a time. Front and back operations pass from acceptance
// through the decide, update and done states to the response beat; a sorted insert or a
// delete by key walks the list one entry per cycle through the single read port of the entry
// store, up to the end of the held entries. The response sits in an output register,
// so the next command is accepted while a finished response still waits for its sink.
// There is no initialization pass after reset: the list is empty as soon as reset drops.
`timescale 1ns / 1ps
`default_nettype none

module ordered_key_list_engine import okl_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  okl_cmd_if.sink   cmd,
  okl_rsp_if.source rsp
);

  okl_cmd_t  ctl_cmd;
  okl_stat_t ctl_stat;
  status_t   out_status;

  okl_controller u_ctl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd.valid),
    .in_ready (cmd.ready),
    .stat     (ctl_stat),
    .cmd      (ctl_cmd)
  );

  okl_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (ctl_cmd),
    .stat        (ctl_stat),
    .in_action   (cmd.action),
    .in_key      (cmd.key),
    .out_ready   (rsp.ready),
    .out_valid   (rsp.valid),
    .out_status  (out_status),
    .out_count   (rsp.entry_count),
    .out_removed (rsp.removed_key)
  );

  assign rsp.status = out_status;

endmodule

`default_nettype wire

// ===== tb/ordered_key_list_engine_tb.sv =====
`timescale 1ns / 1ps

module ordered_key_list_engine_tb import okl_pkg::*; ();

  // Action codes the block must ignore.
  localparam logic [ACT_W-1:0] ACT_UNUSED_LO = ACT_W'(6);
  localparam logic [ACT_W-1:0] ACT_UNUSED_HI = ACT_W'(7);

  localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
  localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

  localparam int PHASE_COUNT    = 8;
  localparam int PHASE_ITEMS    = 175;
  localparam int LONG_HOLD      = 300;
  localparam int SETTLE_CYCLES  = 25;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int REPORT_LIMIT   = 10;

  typedef struct {
    status_t                 status;
    logic [COUNT_W-1:0]      count;
    logic signed [KEY_W-1:0] removed;
  } rsp_beat_t;

  // Tracks the list contents and the responses still owed by the block.
  class key_list_tracker;
    logic signed [KEY_W-1:0] held[$];
    rsp_beat_t               awaited[$];
    int                      mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Applies one accepted command to the tracked list and queues its response.
    function void note_command(logic [ACT_W-1:0] act, logic signed [KEY_W-1:0] k);
      rsp_beat_t due;
      int        pos;
      due.status  = ST_OK;
      due.removed = '0;
      case (act)
        ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_SORTED: begin
          if (held.size() >= CAPACITY) begin
            due.status = ST_FULL;
          end else if (act == ACT_INS_FRONT) begin
            held.push_front(k);
          end else if (act == ACT_INS_BACK) begin
            held.push_back(k);
          end else begin
            // A key not below the head always lands behind it.
            pos = 0;
            if (held.size() != 0 && k >= held[0]) begin
              pos = 1;
              while (pos < held.size() && held[pos] < k) pos++;
            end
            held.insert(pos, k);
          end
        end
        ACT_DEL_FRONT, ACT_DEL_BACK, ACT_DEL_KEY: begin
          if (held.size() == 0) begin
            due.status = ST_EMPTY;
          end else if (act == ACT_DEL_FRONT) begin
            due.removed = held.pop_front();
          end else if (act == ACT_DEL_BACK) begin
            due.removed = held.pop_back();
          end else begin
            pos = 0;
            while (pos < held.size() && held[pos] != k) pos++;
            if (pos < held.size()) begin
              due.removed = held[pos];
              held.delete(pos);
            end else begin
              due.status = ST_NOTFOUND;
            end
          end
        end
        default: ;
      endcase
      due.count = COUNT_W'(held.size());
      awaited.push_back(due);
    endfunction

    // Compares one response beat with the oldest outstanding expectation.
    function void check_response(logic [STAT_W-1:0] st, logic [COUNT_W-1:0] cnt,
                                 logic signed [KEY_W-1:0] rem);
      rsp_beat_t due;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: response beat with no command outstanding: status %0d count %0d",
                   $realtime, st, cnt);
        return;
      end
      due = awaited.pop_front();
      if (st !== due.status || cnt !== due.count || rem !== due.removed) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: mismatch: status %0d/%0d count %0d/%0d removed %0d/%0d (exp/got)",
                   $realtime, due.status, st, due.count, cnt, due.removed, rem);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   hold_left;
  int   cycle_count;

  key_list_tracker tracker;

  okl_cmd_if cmd_ch ();
  okl_rsp_if rsp_ch ();

  ordered_key_list_engine i_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("ordered_key_list_engine_tb NOT OK");
      $finish;
    end
  end

  // Response side: checks each beat and picks the next ready level.
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (rsp_ch.valid && rsp_ch.ready)
          tracker.check_response(rsp_ch.status, rsp_ch.entry_count, rsp_ch.removed_key);
        if (hold_left > 0) begin
          hold_left--;
          rsp_ch.ready <= 1'b0;
        end else begin
          rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
      end
    end
  end

  // Keys lean toward a small pool so that duplicates and equal compares are common.
  function automatic logic signed [KEY_W-1:0] random_key();
    case ($urandom_range(9))
      0:       return KEY_MIN;
      1:       return KEY_MAX;
      2, 3, 4: return KEY_W'(int'($urandom_range(8)) - 4);
      default: return KEY_W'($urandom);
    endcase
  endfunction

  // Offers one command beat, with random idle cycles first, and waits for acceptance.
  task automatic send_command(input logic [ACT_W-1:0] act, input logic signed [KEY_W-1:0] k);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid  <= 1'b1;
    cmd_ch.action <= act;
    cmd_ch.key    <= k;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    tracker.note_command(act, k);
  endtask

  // Stops offering commands until every response has come back.
  task automatic drain_responses();
    cmd_ch.valid <= 1'b0;
    do @(posedge clk); while (tracker.awaited.size() != 0);
  endtask

  initial begin
    logic [ACT_W-1:0]        act;
    logic signed [KEY_W-1:0] k;
    int                      insert_pct;
    int                      roll;

    tracker        = new();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 0;
    rst           <= 1'b1;
    cmd_ch.valid  <= 1'b0;
    cmd_ch.action <= ACT_INS_FRONT;
    cmd_ch.key    <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: deletes and ignored codes on an empty list.
    send_command(ACT_DEL_FRONT, KEY_W'(1));
    send_command(ACT_DEL_BACK, KEY_W'(2));
    send_command(ACT_DEL_KEY, KEY_W'(5));
    send_command(ACT_UNUSED_LO, KEY_MAX);
    send_command(ACT_UNUSED_HI, KEY_MIN);
    // Sorted inserts: into an empty list, equal to the head, and both extremes.
    send_command(ACT_INS_SORTED, KEY_W'(0));
    send_command(ACT_INS_SORTED, KEY_W'(0));
    send_command(ACT_INS_SORTED, KEY_MIN);
    send_command(ACT_INS_SORTED, KEY_MAX);
    send_command(ACT_INS_SORTED, KEY_W'(-1));
    send_command(ACT_INS_FRONT, KEY_MAX);
    send_command(ACT_INS_BACK, KEY_MIN);
    // Deletes on a populated list, including a miss and a hit by key.
    send_command(ACT_DEL_KEY, KEY_W'(7));
    send_command(ACT_DEL_KEY, KEY_W'(0));
    send_command(ACT_DEL_KEY, KEY_MAX);
    send_command(ACT_DEL_FRONT, KEY_W'(0));
    send_command(ACT_DEL_BACK, KEY_W'(0));
    send_command(ACT_UNUSED_LO, KEY_W'(3));
    drain_responses();

    // Random phases: each idling pattern twice, with fill and drain biased slices.
    insert_pct = 85;
    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      // Long response hold-off so the block backs up and stalls its input.
      if (p == 0) hold_left = LONG_HOLD;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 40 == 0) begin
          case ($urandom_range(2))
            0:       insert_pct = 85;
            1:       insert_pct = 50;
            default: insert_pct = 20;
          endcase
        end
        roll = $urandom_range(99);
        k    = random_key();
        if (roll < 3) begin
          act = $urandom_range(1) ? ACT_UNUSED_HI : ACT_UNUSED_LO;
        end else if ($urandom_range(99) < insert_pct) begin
          case ($urandom_range(3))
            0:       act = ACT_INS_FRONT;
            1:       act = ACT_INS_BACK;
            default: act = ACT_INS_SORTED;
          endcase
        end else begin
          case ($urandom_range(3))
            0:       act = ACT_DEL_FRONT;
            1:       act = ACT_DEL_BACK;
            default: act = ACT_DEL_KEY;
          endcase
          // Most deletes by key name an entry that is present.
          if (act == ACT_DEL_KEY && tracker.held.size() != 0 && $urandom_range(99) < 65)
            k = tracker.held[$urandom_range(tracker.held.size() - 1)];
        end
        send_command(act, k);
      end
      if (p % 2 == 1) drain_responses();
    end

    // Wind down and let any trailing beat show up.
    drain_responses();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.awaited.size() == 0) begin
      $display("ordered_key_list_engine_tb OK");
    end else begin
      $display("ordered_key_list_engine_tb NOT OK");
    end
    $finish;
  end

endmodule
